FILE: rtl/core/crc32c_pkg.sv
// shared types, constants and crc matrix functions for the crc-32c engine
package crc32c_pkg;

    localparam logic [31:0] CRC_POLY      = 32'h82F6_3B78;
    localparam logic [31:0] CRC_FINAL_XOR = 32'hFFFF_FFFF;
    localparam int          WORD_BYTES    = 8;
    localparam int          WORD_BITS     = 64;
    localparam int          CRC_BITS      = 32;
    localparam int          QUEUE_DEPTH   = 4;
    localparam int          QUEUE_AW      = $clog2(QUEUE_DEPTH);

    typedef logic [3:0] t_nbytes;

    // one classified word travelling from front to back
    typedef struct packed {
        logic [CRC_BITS-1:0] data_crc;
        t_nbytes             nbytes;
        logic                first;
        logic                last;
        logic [CRC_BITS-1:0] seed;
    } t_entry;

    // column images: running value advanced by n zero bytes, n = 0..8
    typedef logic [WORD_BYTES:0][CRC_BITS-1:0][CRC_BITS-1:0] t_adv_tab;
    // column images: contribution of each data bit over a full word, from zero
    typedef logic [WORD_BITS-1:0][CRC_BITS-1:0] t_data_tab;

    // one reflected bit step
    function automatic logic [CRC_BITS-1:0] bit_step(logic [CRC_BITS-1:0] acc, logic din);
        logic fb;
        fb = acc[0] ^ din;
        return (acc >> 1) ^ (fb ? CRC_POLY : '0);
    endfunction

    // elaboration-time table of zero-byte advance matrices
    function automatic t_adv_tab build_adv_tab();
        t_adv_tab            tab;
        logic [CRC_BITS-1:0] acc;
        for (int n = 0; n <= WORD_BYTES; n++) begin
            for (int i = 0; i < CRC_BITS; i++) begin
                acc = '0;
                acc[i] = 1'b1;
                for (int k = 0; k < 8 * n; k++) begin
                    acc = bit_step(acc, 1'b0);
                end
                tab[n][i] = acc;
            end
        end
        return tab;
    endfunction

    // elaboration-time table of per-data-bit contributions
    function automatic t_data_tab build_data_tab();
        t_data_tab           tab;
        logic [CRC_BITS-1:0] acc;
        for (int j = 0; j < WORD_BITS; j++) begin
            acc = '0;
            for (int k = 0; k < WORD_BITS; k++) begin
                acc = bit_step(acc, (k == j));
            end
            tab[j] = acc;
        end
        return tab;
    endfunction

    localparam t_adv_tab  ADV_TAB  = build_adv_tab();
    localparam t_data_tab DATA_TAB = build_data_tab();

    // running value advanced by nbytes zero bytes: one xor tree per output bit
    function automatic logic [CRC_BITS-1:0] apply_adv(logic [CRC_BITS-1:0] acc,
                                                      t_nbytes nbytes);
        logic [CRC_BITS-1:0] res;
        res = '0;
        for (int i = 0; i < CRC_BITS; i++) begin
            res = res ^ (acc[i] ? ADV_TAB[nbytes][i] : '0);
        end
        return res;
    endfunction

    // crc from zero of a full word whose valid bytes sit in the top lanes
    function automatic logic [CRC_BITS-1:0] apply_data(logic [WORD_BITS-1:0] word);
        logic [CRC_BITS-1:0] res;
        res = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            res = res ^ (word[j] ? DATA_TAB[j] : '0);
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/crc32c_front.sv
// front end: accepts words, clamps byte count, folds data into a seed-free crc term
module crc32c_front import crc32c_pkg::*; (
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [63:0]          i_data_word,
    input  logic [3:0]           i_byte_count,
    input  logic                 i_first_word,
    input  logic                 i_last_word,
    input  logic [31:0]          i_seed,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_entry               o_entry
);

    t_nbytes     nbytes;
    logic [6:0]  shamt;
    logic [63:0] top_aligned;

    // clamp count to a full word
    assign nbytes = (i_byte_count > t_nbytes'(WORD_BYTES)) ? t_nbytes'(WORD_BYTES)
                                                           : i_byte_count;

    // move valid bytes to the top lanes; leading zero bytes leave a zero crc unchanged
    assign shamt       = 7'(WORD_BITS) - {nbytes, 3'b000};
    assign top_aligned = i_data_word << shamt;

    // classified word into the queue
    always_comb begin
        o_entry.data_crc = apply_data(top_aligned);
        o_entry.nbytes   = nbytes;
        o_entry.first    = i_first_word;
        o_entry.last     = i_last_word;
        o_entry.seed     = i_seed;
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

FILE: rtl/core/crc32c_queue.sv
// small fifo between the front and back ends
module crc32c_queue import crc32c_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_entry
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/crc32c_back.sv
// back end: updates the running crc and holds the finished result
module crc32c_back import crc32c_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_entry      i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_crc_value
);

    logic [31:0] r_run_crc;
    logic [31:0] n_run_crc;
    logic        r_out_valid;
    logic [31:0] r_out_crc;
    logic        out_free;
    logic [31:0] start_crc;

    // output slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = !i_q_empty && (!i_entry.last || out_free);

    // seed load, then advance by the byte count and add the data term
    assign start_crc = i_entry.first ? ~i_entry.seed : r_run_crc;
    assign n_run_crc = apply_adv(start_crc, i_entry.nbytes) ^ i_entry.data_crc;

    // running value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_crc <= '0;
        end else if (o_pop) begin
            r_run_crc <= n_run_crc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_entry.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_out_crc <= n_run_crc ^ CRC_FINAL_XOR;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_crc_value = r_out_crc;

endmodule

FILE: rtl/core/crc32c_stream_engine.sv
// crc-32c engine: an accepted last word passes through the queue, then its result is registered in the result reg
// throughput one 64-bit word per cycle while the queue is not full, set by the running-crc update:
//   one 32x32 xor matrix for the chosen byte count plus the data term each cycle
// a four-entry queue decouples the front end from the back end
//   a last word waits there while an earlier result is held by a stall
// reset (synchronous, active low) clears the running crc to zero, the queue and the result valid flag
module crc32c_stream_engine import crc32c_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic [31:0] i_seed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_crc_value
);

    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    t_entry front_entry;
    t_entry head_entry;

    // word intake and classification
    crc32c_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .i_seed       (i_seed),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_entry      (front_entry)
    );

    // decoupling queue
    crc32c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_entry (head_entry)
    );

    // crc update and result
    crc32c_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_entry     (head_entry),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_crc_value (o_crc_value)
    );

endmodule

FILE: tb/sv/tb_crc32c_stream_engine.sv
// testbench for the crc-32c stream engine: directed and random words checked by a scoreboard
`timescale 1ns / 1ps

module tb_crc32c_stream_engine;
    import crc32c_pkg::*;

    localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F6_3B78;
    localparam logic [31:0] OUT_INVERT      = 32'hFFFF_FFFF;
    localparam int          RANDOM_WORDS    = 1950;
    localparam int          LONG_HOLD       = 300;
    localparam int          SETTLE_CYCLES   = 20;

    // running crc copy and queue of expected checksums
    class crc32c_scoreboard;
        logic [31:0] run_crc;
        logic [31:0] crc_expq[$];
        int          errors;

        function new();
            run_crc = '0;
            errors  = 0;
        endfunction

        function logic [31:0] fold_octet(logic [31:0] acc, logic [7:0] octet);
            logic [31:0] r;
            r = acc ^ {24'd0, octet};
            for (int b = 0; b < 8; b++) begin
                r = r[0] ? ((r >> 1) ^ CASTAGNOLI_POLY) : (r >> 1);
            end
            return r;
        endfunction

        // fold one accepted word into the running crc
        function void note_word(logic [63:0] w, t_nbytes n, logic f, logic l, logic [31:0] s);
            int          lanes;
            logic [31:0] acc;
            lanes = (n > 8) ? 8 : int'(n);
            acc   = f ? ~s : run_crc;
            for (int k = 0; k < lanes; k++) begin
                acc = fold_octet(acc, w[8*k +: 8]);
            end
            run_crc = acc;
            if (l) crc_expq.push_back(acc ^ OUT_INVERT);
        endfunction

        // compare one delivered checksum with the oldest expectation
        function void check_crc(logic [31:0] got);
            logic [31:0] want;
            if (crc_expq.size() == 0) begin
                $error("crc_value: no checksum expected, actual %h", got);
                errors++;
            end else begin
                want = crc_expq.pop_front();
                if (got !== want) begin
                    $error("crc_value: expected %h, actual %h", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return crc_expq.size();
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [63:0] i_data_word  = '0;
    logic [3:0]  i_byte_count = 4'd8;
    logic        i_first_word = 1'b0;
    logic        i_last_word  = 1'b0;
    logic [31:0] i_seed       = '0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_crc_value;

    crc32c_scoreboard sb = new();
    bit hold_req = 1'b0;
    bit no_idle  = 1'b0;

    crc32c_stream_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .i_seed       (i_seed),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_crc_value  (o_crc_value)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 64'd0;
        if (r == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] rand_seed();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'd0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    // offer one word, wait until it is taken
    task automatic send_word(input logic [63:0] w, input t_nbytes n, input logic f,
                             input logic l, input logic [31:0] s);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_word  <= w;
        i_byte_count <= n;
        i_first_word <= f;
        i_last_word  <= l;
        i_seed       <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // drop valid and wait for every checksum to come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // accepted words and checksums go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_crc(o_crc_value);
            if (i_valid && !o_stall) begin
                sb.note_word(i_data_word, i_byte_count, i_first_word, i_last_word, i_seed);
            end
        end
    end

    // result side back-pressure
    initial begin
        int run;
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (no_idle) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 8);
                i_stall <= 1'b0;
                repeat (run) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int          words;
        int          len;
        int          kind;
        bit          did_hold;
        bit          did_drain;
        logic [31:0] seed;
        t_nbytes     n;
        logic        lst;

        did_hold  = 1'b0;
        did_drain = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no first since reset, running value still zero
        send_word('1, 4'd8, 1'b0, 1'b1, 32'h1234_5678);
        // empty word that is first and last returns the seed
        send_word(64'h0123_4567_89AB_CDEF, 4'd0, 1'b1, 1'b1, 32'hDEAD_BEEF);
        send_word(64'd0, 4'd8, 1'b1, 1'b1, 32'd0);
        send_word('1, 4'd8, 1'b1, 1'b1, '1);
        // "123456789" over two words
        send_word(64'h3837_3635_3433_3231, 4'd8, 1'b1, 1'b0, 32'd0);
        send_word(64'h0000_0000_0000_0039, 4'd1, 1'b0, 1'b1, 32'd0);
        // every byte count from one to eight on its own
        for (int c = 1; c <= 8; c++) begin
            send_word(64'hA5C3_0F96_5A3C_F069, t_nbytes'(c), 1'b1, 1'b1, 32'h8000_0001);
        end
        // byte counts above eight saturate
        send_word(64'hFEDC_BA98_7654_3210, 4'd9, 1'b1, 1'b1, 32'h0F0F_0F0F);
        send_word(64'hFEDC_BA98_7654_3210, 4'd15, 1'b1, 1'b1, 32'h0F0F_0F0F);
        // words after a last continue from the final value
        send_word(64'h1122_3344_5566_7788, 4'd8, 1'b0, 1'b0, 32'hFFFF_0000);
        send_word(64'h99AA_BBCC_DDEE_FF00, 4'd4, 1'b0, 1'b1, 32'h0000_FFFF);
        // empty word in the middle of a message
        send_word(64'h0000_0000_0000_00FF, 4'd8, 1'b1, 1'b0, 32'hCAFE_F00D);
        send_word('1, 4'd0, 1'b0, 1'b0, 32'd0);
        send_word(64'h8000_0000_0000_0001, 4'd8, 1'b0, 1'b1, 32'd0);
        // empty last word after data
        send_word(64'h5555_AAAA_5555_AAAA, 4'd8, 1'b1, 1'b0, '1);
        send_word(64'd0, 4'd0, 1'b0, 1'b1, '1);

        // random messages, mostly well formed
        words = 0;
        while (words < RANDOM_WORDS) begin
            if (!did_hold && words >= 300) begin
                hold_req = 1'b1;
                did_hold = 1'b1;
            end
            if (!did_drain && words >= 900) begin
                drain();
                did_drain = 1'b1;
            end
            no_idle = (words >= 1200 && words < 1400);
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                len  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 12);
                seed = rand_seed();
                for (int k = 0; k < len; k++) begin
                    lst = (k == len - 1);
                    if ($urandom_range(0, 19) == 0) n = t_nbytes'($urandom_range(0, 15));
                    else if (lst) n = t_nbytes'($urandom_range(1, 8));
                    else n = ($urandom_range(0, 9) < 8) ? 4'd8 : t_nbytes'($urandom_range(1, 7));
                    send_word(rand_word(), n, (k == 0), lst, (k == 0) ? seed : $urandom());
                    words++;
                end
            end else begin
                // stray word with arbitrary flags
                send_word(rand_word(), t_nbytes'($urandom_range(0, 15)), 1'($urandom()),
                          1'($urandom()), rand_seed());
                words++;
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/crc32c_pkg.sv
rtl/core/crc32c_front.sv
rtl/core/crc32c_queue.sv
rtl/core/crc32c_back.sv
rtl/core/crc32c_stream_engine.sv
tb/sv/tb_crc32c_stream_engine.sv
